>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the level gain slicer.
// Depends on nothing; included by pcm_level_gain_slicer, which carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pgs_pkg.sv
// Package for the level gain slicer: defaults, codes, state type and
// G.711 ladder and codeword functions. Depends on nothing.
package pgs_pkg;

    localparam int BLK_SIZE_DEF  = 240;
    localparam int REF_INDEX_DEF = 64;
    localparam int DC_SHIFT_DEF  = 13;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_LAW      = 2'd0;
    localparam logic [1:0] REG_FREEZE   = 2'd1;
    localparam logic [1:0] REG_MIN_PEAK = 2'd2;

    localparam logic LAW_MU = 1'b0;
    localparam logic LAW_A  = 1'b1;

    localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;
    localparam logic [23:0] GAIN_RESET = 24'h010000;
    localparam logic [15:0] MIN_PEAK_RESET = 16'd40;

    // Dividend width: ladder magnitude (15 bits) shifted by 24, plus rounding carry.
    localparam int DIV_W = 40;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_MUL, S_SAT, S_SRCH, S_PICK, S_OUT,
        S_SNAP, S_PEAK, S_UPD, S_DINIT, S_DIV, S_GAIN
    } t_state;

    // Magnitude of a Ucode on the decoding ladder.
    function automatic logic [14:0] ladder(input logic law, input logic [6:0] u);
        logic [2:0]  seg;
        logic [3:0]  man;
        logic [15:0] t;
        seg = u[6:4];
        man = u[3:0];
        if (law == LAW_A) begin
            if (seg == 3'd0) begin
                t = {8'd0, man, 4'd8};
            end else begin
                t = (16'({man, 4'd0}) + 16'd264) << (seg - 3'd1);
            end
        end else begin
            t = ((16'({man, 3'd0}) + 16'd132) << seg) - 16'd132;
        end
        return t[14:0];
    endfunction

    // PCM octet for a Ucode and a sign.
    function automatic logic [7:0] compose(input logic law, input logic [6:0] u,
                                           input logic positive);
        if (law == LAW_A) begin
            return {positive, u} ^ 8'h55;
        end
        return (positive ? 8'hFF : 8'h7F) - {1'b0, u};
    endfunction

endpackage

>>> hw/rtl/pgs_in_if.sv
// Input channel of the level gain slicer: valid, ready and one sample.
// Depends on nothing.
interface pgs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> hw/rtl/pgs_out_if.sv
// Output channel of the level gain slicer: valid, ready and one result item.
// Depends on nothing.
interface pgs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  codeword;
    logic [6:0]  ucode;
    logic        block_end;
    logic        level_valid;
    logic [23:0] gain_now;
    logic [15:0] level_now;
    logic        gain_frozen;

    modport source (output valid, output codeword, output ucode, output block_end,
                    output level_valid, output gain_now, output level_now,
                    output gain_frozen, input ready);
    modport sink   (input valid, input codeword, input ucode, input block_end,
                    input level_valid, input gain_now, input level_now,
                    input gain_frozen, output ready);
endinterface

>>> hw/rtl/pcm_level_gain_slicer.sv
// Top level of the level gain slicer: sequencer, sample store and datapath.
// Depends on pgs_pkg, pgs_in_if, pgs_out_if and assert_macros.svh.
//
// Turns signed linear samples into G.711 octets after normalizing the line
// level. Results lag the input by one block of BLK_SIZE samples; the first
// block yields no results, and its items are accepted one per cycle. Once
// results flow, an ordinary item passes from the store read at acceptance
// through a sign and magnitude step, a multiply, a saturation step, a
// 7-step binary search of the ladder through one shared compare unit
// (skipped while no level is held), a rounding pick, then the output load.
// The last item of a block goes on to the dc snapshot, peak, level update
// and a one-bit-per-cycle 40-step gain division; the division is skipped
// when the level is left unchanged or the new level is zero. The result
// sits in an output register, so the next item is accepted while it waits;
// the output load stalls only if the previous result is still untaken.
`include "assert_macros.svh"

module pcm_level_gain_slicer import pgs_pkg::*; #(
    parameter int BLK_SIZE  = BLK_SIZE_DEF,
    parameter int REF_INDEX = REF_INDEX_DEF,
    parameter int DC_SHIFT  = DC_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    pgs_in_if.sink      i_in,
    pgs_out_if.source   o_out
);

    localparam int POS_W = $clog2(BLK_SIZE);
    localparam int MEM_D = 2 * BLK_SIZE;
    localparam int MEM_AW = $clog2(MEM_D);
    localparam logic [6:0] REF_U = 7'(REF_INDEX);

    t_state r_state, n_state;

    // Configuration registers.
    logic        r_law, r_freeze;
    logic [15:0] r_min_peak;

    // Block state.
    logic signed [31:0] r_acc;
    logic [POS_W-1:0]   r_pos;
    logic               r_bank, r_hold, r_blk;
    logic signed [15:0] r_max, r_min;
    logic signed [16:0] r_snap;
    logic [16:0]        r_peak;
    logic [23:0]        r_level, r_gain;
    logic               r_have;

    // Per-item datapath.
    logic signed [15:0] mem [MEM_D];
    logic signed [15:0] r_rd;
    logic               r_positive;
    logic [16:0]        r_mag;
    logic [40:0]        r_prod;
    logic [30:0]        r_m;
    logic [6:0]         r_u;
    logic [5:0]         r_cnt;

    // Divider.
    logic [DIV_W-1:0]   r_num, r_q;
    logic [24:0]        r_rem;

    // Output register.
    logic        r_ov;
    logic [7:0]  r_cw;
    logic [6:0]  r_ou;
    logic        r_oblk, r_ohave, r_ofrz;
    logic [23:0] r_ogain;
    logic [15:0] r_olevel;

    logic accept;
    logic out_free;
    logic [MEM_AW-1:0] wr_addr, rd_addr;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign wr_addr = r_bank ? MEM_AW'(BLK_SIZE) + MEM_AW'(r_pos) : MEM_AW'(r_pos);
    assign rd_addr = r_bank ? MEM_AW'(r_pos) : MEM_AW'(BLK_SIZE) + MEM_AW'(r_pos);

    // Shared slicer compare terms.
    logic [6:0]  cand;
    logic [14:0] lad_c, lad_u, lad_n;
    logic [15:0] lad_sum;
    assign cand    = r_u | (7'd1 << r_cnt[2:0]);
    assign lad_c   = ladder(r_law, cand);
    assign lad_u   = ladder(r_law, r_u);
    assign lad_n   = ladder(r_law, r_u + 7'd1);
    assign lad_sum = 16'(lad_u) + 16'(lad_n);

    // Datapath combinational terms.
    logic signed [17:0] v;
    logic signed [31:0] acc_next, x_ext;
    logic signed [17:0] pk_a, pk_b, pk_m;
    logic [26:0]        lvl_ema;
    logic [23:0]        lvl_new;
    logic [14:0]        ref_mag;
    logic [24:0]        rem_sh;
    logic [40:0]        top_q;

    assign v        = 18'(r_rd) - 18'(r_snap);
    assign x_ext    = 32'(i_in.sample);
    assign acc_next = r_acc + x_ext - (r_acc >>> DC_SHIFT);
    assign pk_a     = 18'(r_max) - 18'(r_snap);
    assign pk_b     = 18'(r_snap) - 18'(r_min);
    assign pk_m     = (pk_a > pk_b) ? pk_a : pk_b;
    assign lvl_ema  = 27'(r_level) * 27'd3 + 27'({r_peak, 8'd0}) + 27'd2;
    assign lvl_new  = r_have ? lvl_ema[25:2] : 24'({r_peak, 8'd0});
    assign ref_mag  = (ladder(r_law, REF_U) == 15'd0) ? 15'd1 : ladder(r_law, REF_U);
    assign rem_sh   = {r_rem[23:0], r_num[DIV_W-1]};
    assign top_q    = 41'({ladder(r_law, 7'd127), 16'd0});

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_hold) begin
                        n_state = S_RD;
                    end else if (r_pos == POS_W'(BLK_SIZE - 1)) begin
                        n_state = S_SNAP;
                    end
                end
            end
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = S_SAT;
            S_SAT:  n_state = r_have ? S_SRCH : S_PICK;
            S_SRCH: n_state = (r_cnt == 6'd0) ? S_PICK : S_SRCH;
            S_PICK: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = r_blk ? S_SNAP : S_IDLE;
                end
            end
            S_SNAP: n_state = S_PEAK;
            S_PEAK: n_state = S_UPD;
            S_UPD: begin
                if (!(r_freeze && r_have) && (r_peak >= 17'(r_min_peak))) begin
                    n_state = S_DINIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DINIT: n_state = (r_level == 24'd0) ? S_IDLE : S_DIV;
            S_DIV:   n_state = (r_cnt == 6'd0) ? S_GAIN : S_DIV;
            S_GAIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_law      <= LAW_MU;
            r_freeze   <= 1'b0;
            r_min_peak <= MIN_PEAK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LAW:      r_law      <= i_cfg_data[0];
                REG_FREEZE:   r_freeze   <= i_cfg_data[0];
                REG_MIN_PEAK: r_min_peak <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sample store: one write and one registered read per accepted item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[wr_addr] <= i_in.sample;
            r_rd         <= mem[rd_addr];
        end
    end

    // Control and block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pos   <= '0;
            r_bank  <= 1'b0;
            r_hold  <= 1'b0;
            r_blk   <= 1'b0;
            r_max   <= 16'sh8000;
            r_min   <= 16'sh7FFF;
            r_snap  <= '0;
            r_level <= '0;
            r_gain  <= GAIN_RESET;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_acc <= acc_next;
                        if (i_in.sample > r_max) r_max <= i_in.sample;
                        if (i_in.sample < r_min) r_min <= i_in.sample;
                        r_blk <= (r_pos == POS_W'(BLK_SIZE - 1));
                        if (r_pos == POS_W'(BLK_SIZE - 1)) begin
                            r_pos  <= '0;
                            r_bank <= !r_bank;
                            r_hold <= 1'b1;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                        end
                    end
                end
                S_SAT: r_cnt <= 6'd6;
                S_SRCH: begin
                    if (r_cnt != 6'd0) r_cnt <= r_cnt - 6'd1;
                end
                S_OUT: begin
                    if (out_free) r_ov <= 1'b1;
                end
                S_SNAP: begin
                    r_snap <= 17'((r_acc + (32'sd1 <<< (DC_SHIFT - 1))) >>> DC_SHIFT);
                end
                S_PEAK: begin
                    r_max <= 16'sh8000;
                    r_min <= 16'sh7FFF;
                end
                S_UPD: begin
                    if (!(r_freeze && r_have) && (r_peak >= 17'(r_min_peak))) begin
                        r_level <= lvl_new;
                        r_have  <= 1'b1;
                    end
                end
                S_DINIT: begin
                    r_cnt <= 6'(DIV_W - 1);
                    if (r_level == 24'd0) r_gain <= GAIN_MAX;
                end
                S_DIV: begin
                    if (r_cnt != 6'd0) r_cnt <= r_cnt - 6'd1;
                end
                S_GAIN: begin
                    r_gain <= (r_q[DIV_W-1:24] != '0) ? GAIN_MAX : r_q[23:0];
                end
                default: ;
            endcase
        end
    end

    // Payload registers of the per-item path, divider and output.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_RD: begin
                r_positive <= (v >= 0);
                r_mag      <= (v >= 0) ? 17'(v) : 17'(-v);
            end
            S_MUL: r_prod <= 41'(r_mag) * 41'(r_gain);
            S_SAT: begin
                r_m <= (r_prod > top_q) ? top_q[30:0] : r_prod[30:0];
                r_u <= 7'd0;
            end
            S_SRCH: begin
                if ({lad_c, 16'd0} <= r_m) r_u <= cand;
            end
            S_PICK: begin
                if (r_have && (r_u != 7'd127) && ({r_m, 1'b0} > {lad_sum, 16'd0})) begin
                    r_u <= r_u + 7'd1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_cw     <= compose(r_law, r_u, r_positive);
                    r_ou     <= r_u;
                    r_oblk   <= r_blk;
                    r_ohave  <= r_have;
                    r_ogain  <= r_gain;
                    r_olevel <= r_level[23:8];
                    r_ofrz   <= r_freeze && r_have;
                end
            end
            S_PEAK: r_peak <= pk_m[17] ? 17'd0 : pk_m[16:0];
            S_DINIT: begin
                r_num <= DIV_W'({ref_mag, 24'd0}) + DIV_W'(r_level[23:1]);
                r_rem <= '0;
                r_q   <= '0;
            end
            S_DIV: begin
                r_num <= r_num << 1;
                if (rem_sh >= 25'(r_level)) begin
                    r_rem <= rem_sh - 25'(r_level);
                    r_q   <= {r_q[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[DIV_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid       = r_ov;
    assign o_out.codeword    = r_cw;
    assign o_out.ucode       = r_ou;
    assign o_out.block_end   = r_oblk;
    assign o_out.level_valid = r_ohave;
    assign o_out.gain_now    = r_ogain;
    assign o_out.level_now   = r_olevel;
    assign o_out.gain_frozen = r_ofrz;

    // Checks on the sequencer and the result path.
    `PGS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept && (r_hold || (r_pos == POS_W'(BLK_SIZE - 1))), !i_in.ready, "ready after accept")
    `PGS_ASSERT_NOW(a_out_needs_hold, i_clk, i_rst_n, r_ov, r_hold, "result before first block")
    `PGS_ASSERT_NOW(a_no_level_zero_u, i_clk, i_rst_n, r_ov && !r_ohave, r_ou == 7'd0, "ucode without level")
    `PGS_ASSERT_NOW(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt <= 6'(DIV_W - 1), "divider count")

endmodule
